/* hw/rtl/bgd_pkg.sv */
// package: types, register indexes and reset values for the button gesture detector
`timescale 1ns / 1ps
`default_nettype none
package bgd_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SHORT_MIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SHORT_MAX   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MULTI_WIN   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REPEAT      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_REPORT_INTV = 3'd5;

  // register reset values
  localparam logic [CfgDataW-1:0] SHORT_MIN_RST   = 16'd20;
  localparam logic [CfgDataW-1:0] SHORT_MAX_RST   = 16'd500;
  localparam logic [CfgDataW-1:0] MULTI_WIN_RST   = 16'd300;
  localparam logic [CfgDataW-1:0] LONG_PRESS_RST  = 16'd1000;
  localparam logic [CfgDataW-1:0] REPEAT_RST      = 16'd200;
  localparam logic [CfgDataW-1:0] REPORT_INTV_RST = 16'd100;

  localparam logic [7:0] CLICK_MAX = 8'd255;

  typedef struct packed {
    logic [CfgDataW-1:0] short_min_ms;
    logic [CfgDataW-1:0] short_max_ms;
    logic [CfgDataW-1:0] multi_window_ms;
    logic [CfgDataW-1:0] long_hold_ms;
    logic [CfgDataW-1:0] repeat_ms;
    logic [CfgDataW-1:0] report_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic        down_flag;
    logic [31:0] press_start_time;
    logic [31:0] last_click_time;
    logic [7:0]  click_counter;
    logic        long_seen;
    logic [31:0] window_deadline;
    logic [31:0] next_repeat_time;
    logic [31:0] last_report_time;
  } state_t;

  typedef struct packed {
    logic        press_edge;
    logic        release_edge;
    logic        click;
    logic [7:0]  click_num;
    logic        click_timeout;
    logic [7:0]  final_count;
    logic        duration_report;
    logic [31:0] held_ms;
    logic        long_press;
    logic        long_repeat;
    logic        is_down;
  } result_t;

endpackage
`default_nettype wire

/* hw/rtl/bgd_eval.sv */
// single-poll evaluation: next button state and event flags from one poll
`timescale 1ns / 1ps
`default_nettype none
module bgd_eval (
  input  var bgd_pkg::state_t  st_i,
  input  var bgd_pkg::cfg_t    cfg_i,
  input  wire logic [31:0]     now_ms_i,
  input  wire logic            pressed_i,
  output bgd_pkg::state_t      st_o,
  output bgd_pkg::result_t     res_o
);

  logic [31:0] since_deadline;
  logic [31:0] since_click;
  logic [31:0] rel_dur;
  logic [31:0] held_dur;
  logic [31:0] since_report;
  logic [31:0] since_repeat;
  logic [31:0] win_end;
  logic [31:0] repeat_at;
  logic        expire;
  logic        in_win;
  logic        go_down;
  logic        go_up;
  logic        short_ok;
  bgd_pkg::state_t s1;
  bgd_pkg::state_t s2;
  bgd_pkg::result_t r;

  assign since_deadline = now_ms_i - st_i.window_deadline;
  assign since_click    = now_ms_i - st_i.last_click_time;
  assign rel_dur        = now_ms_i - st_i.press_start_time;
  assign win_end        = now_ms_i + {16'd0, cfg_i.multi_window_ms};
  assign repeat_at      = now_ms_i + {16'd0, cfg_i.repeat_ms};

  // last_click_time never changes before the edge handling, so this holds for both edges
  assign in_win  = (st_i.last_click_time != 32'd0) &&
                   (since_click < {16'd0, cfg_i.multi_window_ms});
  assign expire  = (st_i.click_counter != 8'd0) && (st_i.window_deadline != 32'd0) &&
                   !st_i.down_flag && !since_deadline[31];
  assign go_down = pressed_i && !st_i.down_flag;
  assign go_up   = !pressed_i && st_i.down_flag;
  assign short_ok = (rel_dur >= {16'd0, cfg_i.short_min_ms}) &&
                    (rel_dur <= {16'd0, cfg_i.short_max_ms});

  // held-time checks run on the state after edge handling
  assign held_dur     = now_ms_i - s1.press_start_time;
  assign since_report = now_ms_i - s1.last_report_time;
  assign since_repeat = now_ms_i - s1.next_repeat_time;

  always_comb begin
    s1 = st_i;
    r  = '0;
    // multi-click window expiry, only while released
    if (expire) begin
      r.click_timeout   = 1'b1;
      r.final_count     = st_i.click_counter;
      s1.click_counter  = 8'd0;
      s1.window_deadline = 32'd0;
    end
    if (go_down) begin
      r.press_edge        = 1'b1;
      s1.down_flag        = 1'b1;
      s1.press_start_time = now_ms_i;
      s1.long_seen        = 1'b0;
      s1.next_repeat_time = 32'd0;
      s1.last_report_time = now_ms_i;
      if (in_win) begin
        s1.window_deadline = win_end;
      end
    end else if (go_up) begin
      r.release_edge = 1'b1;
      s1.down_flag   = 1'b0;
      if (short_ok) begin
        if (in_win) begin
          if (s1.click_counter != bgd_pkg::CLICK_MAX) begin
            s1.click_counter = s1.click_counter + 8'd1;
          end
        end else begin
          s1.click_counter = 8'd1;
        end
        r.click            = 1'b1;
        s1.last_click_time = now_ms_i;
        s1.window_deadline = win_end;
      end
      s1.long_seen        = 1'b0;
      s1.next_repeat_time = 32'd0;
    end
  end

  always_comb begin
    s2    = s1;
    res_o = r;
    res_o.click_num = r.click ? s1.click_counter : 8'd0;
    if (s1.down_flag) begin
      if (since_report >= {16'd0, cfg_i.report_interval_ms}) begin
        res_o.duration_report = 1'b1;
        res_o.held_ms         = held_dur;
        s2.last_report_time   = now_ms_i;
      end
      if (held_dur >= {16'd0, cfg_i.long_hold_ms}) begin
        if (!s1.long_seen) begin
          s2.long_seen        = 1'b1;
          res_o.long_press    = 1'b1;
          s2.next_repeat_time = repeat_at;
        end else if ((s1.next_repeat_time != 32'd0) && !since_repeat[31]) begin
          res_o.long_repeat   = 1'b1;
          s2.next_repeat_time = repeat_at;
        end
      end
    end
    res_o.is_down = s1.down_flag;
    st_o = s2;
  end

endmodule
`default_nettype wire

/* hw/rtl/button_gesture_detector.sv */
// top level: button gesture detector with poll input register and result register
`timescale 1ns / 1ps
`default_nettype none
// Classifies polled button samples (millisecond timestamp plus raw level) into press and
// release edges, short clicks with a running multi-click count, multi-click window expiry,
// long press, long-press repeats and periodic held-duration reports, using wrapping 32-bit
// time with zero meaning unset. Every accepted poll yields exactly one result transfer. A poll
// is taken into an input register, evaluated combinationally against the state registers and
// written to the result register; the single evaluation pass allows one poll per cycle while
// out_stall does not hold the result register. The input register can still take a poll while
// a finished result waits on out_stall, and stalls only when both registers are full and the
// result is stalled. Configuration registers are to be written through cfg_we only while
// the block is idle (not enforced by the block); indexes beyond the last register are ignored.
module button_gesture_detector (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [bgd_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [bgd_pkg::CfgDataW-1:0]  cfg_wdata,
  // poll input
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [31:0]                   in_now_ms,
  input  wire logic                          in_pressed,
  // result output
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_press_edge,
  output logic                               out_release_edge,
  output logic                               out_click,
  output logic [7:0]                         out_click_num,
  output logic                               out_click_timeout,
  output logic [7:0]                         out_final_count,
  output logic                               out_duration_report,
  output logic [31:0]                        out_held_ms,
  output logic                               out_long_press,
  output logic                               out_long_repeat,
  output logic                               out_is_down
);

  bgd_pkg::cfg_t    cfg_r;
  bgd_pkg::state_t  st_r;
  bgd_pkg::state_t  st_nxt;
  bgd_pkg::result_t res_r;
  bgd_pkg::result_t res_nxt;

  logic        s1_v_r;
  logic [31:0] s1_now_r;
  logic        s1_pressed_r;
  logic        out_valid_r;
  logic        in_xfer;
  logic        adv;

  // poll in the input register moves on when the result register is free or draining
  assign adv      = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_v_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_min_ms       <= bgd_pkg::SHORT_MIN_RST;
      cfg_r.short_max_ms       <= bgd_pkg::SHORT_MAX_RST;
      cfg_r.multi_window_ms    <= bgd_pkg::MULTI_WIN_RST;
      cfg_r.long_hold_ms       <= bgd_pkg::LONG_PRESS_RST;
      cfg_r.repeat_ms          <= bgd_pkg::REPEAT_RST;
      cfg_r.report_interval_ms <= bgd_pkg::REPORT_INTV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgd_pkg::REG_SHORT_MIN:   cfg_r.short_min_ms       <= cfg_wdata;
        bgd_pkg::REG_SHORT_MAX:   cfg_r.short_max_ms       <= cfg_wdata;
        bgd_pkg::REG_MULTI_WIN:   cfg_r.multi_window_ms    <= cfg_wdata;
        bgd_pkg::REG_LONG_PRESS:  cfg_r.long_hold_ms       <= cfg_wdata;
        bgd_pkg::REG_REPEAT:      cfg_r.repeat_ms          <= cfg_wdata;
        bgd_pkg::REG_REPORT_INTV: cfg_r.report_interval_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register: valid bit under reset, payload plain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_xfer) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_now_r     <= in_now_ms;
      s1_pressed_r <= in_pressed;
    end
  end

  // one-pass evaluation of the buffered poll against the button state
  bgd_eval u_eval (
    .st_i      (st_r),
    .cfg_i     (cfg_r),
    .now_ms_i  (s1_now_r),
    .pressed_i (s1_pressed_r),
    .st_o      (st_nxt),
    .res_o     (res_nxt)
  );

  // button state commits when the poll moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_press_edge      = res_r.press_edge;
  assign out_release_edge    = res_r.release_edge;
  assign out_click           = res_r.click;
  assign out_click_num       = res_r.click_num;
  assign out_click_timeout   = res_r.click_timeout;
  assign out_final_count     = res_r.final_count;
  assign out_duration_report = res_r.duration_report;
  assign out_held_ms         = res_r.held_ms;
  assign out_long_press      = res_r.long_press;
  assign out_long_repeat     = res_r.long_repeat;
  assign out_is_down         = res_r.is_down;

  // a click only comes with the release that ends it
  a_click_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.click |-> res_r.release_edge)
    else $error("click without release edge");

  // long press and its repeats fire only while held
  a_long_while_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.long_press || res_r.long_repeat) |-> res_r.is_down)
    else $error("long press event while released");

  // first long press and a repeat never share one poll
  a_long_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.long_press && res_r.long_repeat))
    else $error("long press and repeat together");

  // a buffered poll that cannot move on stays buffered
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |=> s1_v_r)
    else $error("buffered poll lost");

  // committed down state matches the result just registered
  a_down_track: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> st_r.down_flag == res_r.is_down)
    else $error("down flag and result disagree");

endmodule
`default_nettype wire

/* tb/sv/button_gesture_detector_tb.sv */
// testbench: self-checking poll stream with random idling and backpressure for the gesture detector
`timescale 1ns / 1ps
module button_gesture_detector_tb;

  // run length guard, far above the slowest correct run
  localparam int unsigned CYCLE_LIMIT = 150000;
  // receiver hold-off long enough to fill both registers of the block
  localparam int unsigned HOLD_CYCLES = 60;
  // settle with margin after the last result
  localparam int unsigned SETTLE_CYCLES = 4;
  // register indexes past the last register, writes there must be ignored
  localparam logic [bgd_pkg::CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [bgd_pkg::CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        pressed;
  } poll_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         cfg_we = 1'b0;
  logic [bgd_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [bgd_pkg::CfgDataW-1:0] cfg_wdata = '0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_now_ms = '0;
  logic        in_pressed = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_press_edge;
  logic        out_release_edge;
  logic        out_click;
  logic [7:0]  out_click_num;
  logic        out_click_timeout;
  logic [7:0]  out_final_count;
  logic        out_duration_report;
  logic [31:0] out_held_ms;
  logic        out_long_press;
  logic        out_long_repeat;
  logic        out_is_down;

  // polls waiting to be offered, and predicted events waiting for their result transfer
  poll_t            poll_backlog[$];
  bgd_pkg::result_t predicted_events[$];

  // predictor copy of the registers and of the detector state
  bgd_pkg::cfg_t   cfg;
  bgd_pkg::state_t gs;

  logic [31:0] cursor_ms = 32'hFFFF_F000;  // start near the wrap point
  int unsigned queued = 0;
  bit          in_took = 1'b0;
  bit          calm = 1'b0;                 // no idling on either side while set
  int unsigned hold_reqs = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;

  int unsigned cycles = 0;
  int unsigned errs = 0;
  int unsigned n_polls = 0;
  int unsigned n_results = 0;
  int unsigned n_clicks = 0;
  int unsigned n_expiries = 0;
  int unsigned n_long = 0;
  int unsigned n_repeats = 0;
  int unsigned n_reports = 0;
  int unsigned n_in_stalls = 0;
  int unsigned peak_count = 0;
  bgd_pkg::result_t oldest;
  bgd_pkg::result_t fresh;

  button_gesture_detector u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_now_ms           (in_now_ms),
    .in_pressed          (in_pressed),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_press_edge      (out_press_edge),
    .out_release_edge    (out_release_edge),
    .out_click           (out_click),
    .out_click_num       (out_click_num),
    .out_click_timeout   (out_click_timeout),
    .out_final_count     (out_final_count),
    .out_duration_report (out_duration_report),
    .out_held_ms         (out_held_ms),
    .out_long_press      (out_long_press),
    .out_long_repeat     (out_long_repeat),
    .out_is_down         (out_is_down)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // wrapping time compare: now is at or past mark when the difference is non-negative
  function automatic logic reached(logic [31:0] now, logic [31:0] mark);
    logic [31:0] diff;
    diff = now - mark;
    return ~diff[31];
  endfunction

  // zero click time means no click yet, so never inside the window
  function automatic logic in_window(logic [31:0] now);
    logic [31:0] since;
    since = now - gs.last_click_time;
    return (gs.last_click_time != 32'd0) && (since < {16'd0, cfg.multi_window_ms});
  endfunction

  task automatic classify_poll(input logic [31:0] now, input logic lvl,
                               output bgd_pkg::result_t r);
    logic [31:0] dur;
    logic [31:0] since_report;
    r = '0;
    // window expiry first, settled only while released
    if (gs.click_counter != 8'd0 && gs.window_deadline != 32'd0 && !gs.down_flag &&
        reached(now, gs.window_deadline)) begin
      r.click_timeout = 1'b1;
      r.final_count = gs.click_counter;
      gs.click_counter = 8'd0;
      gs.window_deadline = 32'd0;
    end
    // edges
    if (lvl && !gs.down_flag) begin
      r.press_edge = 1'b1;
      gs.down_flag = 1'b1;
      gs.press_start_time = now;
      gs.long_seen = 1'b0;
      gs.next_repeat_time = 32'd0;
      gs.last_report_time = now;
      if (in_window(now)) begin
        gs.window_deadline = now + {16'd0, cfg.multi_window_ms};
      end
    end else if (!lvl && gs.down_flag) begin
      dur = now - gs.press_start_time;
      r.release_edge = 1'b1;
      gs.down_flag = 1'b0;
      if (dur >= {16'd0, cfg.short_min_ms} && dur <= {16'd0, cfg.short_max_ms}) begin
        // a click outside the window restarts the count, inside it saturates
        if (!in_window(now)) begin
          gs.click_counter = 8'd1;
        end else if (gs.click_counter != bgd_pkg::CLICK_MAX) begin
          gs.click_counter = gs.click_counter + 8'd1;
        end
        r.click = 1'b1;
        r.click_num = gs.click_counter;
        gs.last_click_time = now;
        gs.window_deadline = now + {16'd0, cfg.multi_window_ms};
      end
      gs.long_seen = 1'b0;
      gs.next_repeat_time = 32'd0;
    end
    // held-time checks
    if (gs.down_flag) begin
      dur = now - gs.press_start_time;
      since_report = now - gs.last_report_time;
      if (since_report >= {16'd0, cfg.report_interval_ms}) begin
        r.duration_report = 1'b1;
        r.held_ms = dur;
        gs.last_report_time = now;
      end
      if (dur >= {16'd0, cfg.long_hold_ms}) begin
        if (!gs.long_seen) begin
          gs.long_seen = 1'b1;
          r.long_press = 1'b1;
          gs.next_repeat_time = now + {16'd0, cfg.repeat_ms};
        end else if (gs.next_repeat_time != 32'd0 && reached(now, gs.next_repeat_time)) begin
          r.long_repeat = 1'b1;
          gs.next_repeat_time = now + {16'd0, cfg.repeat_ms};
        end
      end
    end
    r.is_down = gs.down_flag;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_poll(logic [31:0] now, logic lvl);
    poll_t p;
    p.now_ms = now;
    p.pressed = lvl;
    poll_backlog.push_back(p);
    queued++;
  endtask

  // register write on the plain write port, shadow copy updated alongside
  task automatic write_reg(logic [bgd_pkg::CfgIdxW-1:0] idx, logic [bgd_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      bgd_pkg::REG_SHORT_MIN:   cfg.short_min_ms = val;
      bgd_pkg::REG_SHORT_MAX:   cfg.short_max_ms = val;
      bgd_pkg::REG_MULTI_WIN:   cfg.multi_window_ms = val;
      bgd_pkg::REG_LONG_PRESS:  cfg.long_hold_ms = val;
      bgd_pkg::REG_REPEAT:      cfg.repeat_ms = val;
      bgd_pkg::REG_REPORT_INTV: cfg.report_interval_ms = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_regs(logic [15:0] smin, logic [15:0] smax, logic [15:0] mw,
                           logic [15:0] lp, logic [15:0] rp, logic [15:0] ri);
    write_reg(bgd_pkg::REG_SHORT_MIN, smin);
    write_reg(bgd_pkg::REG_SHORT_MAX, smax);
    write_reg(bgd_pkg::REG_MULTI_WIN, mw);
    write_reg(bgd_pkg::REG_LONG_PRESS, lp);
    write_reg(bgd_pkg::REG_REPEAT, rp);
    write_reg(bgd_pkg::REG_REPORT_INTV, ri);
  endtask

  // wait until every poll has been taken and every result has come back
  task automatic settle();
    while (poll_backlog.size() != 0 || in_valid || predicted_events.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // hand-picked polls at the reset register values
  task automatic queue_directed();
    push_poll(32'd0, 1'b0);            // idle at time zero
    push_poll(32'd100, 1'b1);          // press
    push_poll(32'd150, 1'b0);          // short click, count one
    push_poll(32'd200, 1'b1);          // press inside the window moves the deadline
    push_poll(32'd260, 1'b0);          // double click
    push_poll(32'd600, 1'b0);          // window expiry with final count two
    push_poll(32'd700, 1'b1);
    push_poll(32'd705, 1'b0);          // too short for a click
    push_poll(32'd800, 1'b1);
    push_poll(32'd1400, 1'b0);         // too long for a click
    push_poll(32'd2000, 1'b1);
    push_poll(32'd2100, 1'b1);         // held report exactly on the interval
    push_poll(32'd3000, 1'b1);         // long press with report
    push_poll(32'd3200, 1'b1);         // first repeat
    push_poll(32'd3250, 1'b1);
    push_poll(32'd3500, 1'b1);         // second repeat
    push_poll(32'd3600, 1'b0);
    push_poll(32'hFFFF_FF00, 1'b1);    // click just before the time wrap, its window runs across it
    push_poll(32'hFFFF_FFF0, 1'b0);
    push_poll(32'd0, 1'b1);            // press at time zero inside the window
    push_poll(32'h0000_0020, 1'b0);
    push_poll(32'hFFFF_FFFF, 1'b0);    // deadline still ahead across the wrap
    push_poll(32'h0000_014C, 1'b0);    // expiry exactly on the deadline
    push_poll(32'hFFFF_FFD8, 1'b1);
    push_poll(32'd0, 1'b0);            // click landing on time zero reads as unset
    push_poll(32'd100, 1'b1);
    push_poll(32'd150, 1'b0);          // count restarts at one
  endtask

  // press, held samples, release and released samples, shaped by the current registers, plus stray noise polls
  task automatic queue_gestures(int unsigned n);
    int unsigned target;
    int unsigned smin, smax, mw, lp, rp;
    int unsigned hold, gap, nsamp, m, k;
    target = queued + n;
    smin = 32'(cfg.short_min_ms);
    smax = 32'(cfg.short_max_ms);
    mw = 32'(cfg.multi_window_ms);
    lp = 32'(cfg.long_hold_ms);
    rp = 32'(cfg.repeat_ms);
    while (queued < target) begin
      if ($urandom_range(0, 99) < 8) begin
        // noise: stray level after an odd time step or a jump anywhere
        if ($urandom_range(0, 3) == 0) begin
          cursor_ms = $urandom();
        end else begin
          cursor_ms = cursor_ms + $urandom_range(0, 70000);
        end
        push_poll(cursor_ms, 1'($urandom_range(0, 1)));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: hold = (smin <= smax) ? $urandom_range(smin, smax) : $urandom_range(0, smin);
          4: begin
            // click length boundaries
            case ($urandom_range(0, 3))
              0: hold = (smin > 0) ? smin - 1 : 0;
              1: hold = smin;
              2: hold = smax;
              default: hold = smax + 1;
            endcase
          end
          5, 6: hold = lp + $urandom_range(0, 6 * rp);
          7: hold = $urandom_range(smax, lp + rp);
          default: hold = $urandom_range(0, 4000);
        endcase
        nsamp = $urandom_range(0, 10);
        push_poll(cursor_ms, 1'b1);
        for (k = 1; k <= nsamp; k++) begin
          push_poll(cursor_ms + (hold * k) / (nsamp + 1), 1'b1);
        end
        cursor_ms = cursor_ms + hold;
        push_poll(cursor_ms, 1'b0);
        case ($urandom_range(0, 3))
          0, 1: gap = $urandom_range(0, mw - 1);
          2: gap = mw;
          default: gap = mw + $urandom_range(1, 3 * mw + 2000);
        endcase
        m = $urandom_range(0, 2);
        for (k = 1; k <= m; k++) begin
          push_poll(cursor_ms + (gap * k) / m, 1'b0);
        end
        cursor_ms = cursor_ms + gap;
      end
    end
  endtask

  // long run of clicks inside the window to drive the count into saturation
  task automatic queue_click_train(int unsigned n);
    int unsigned smin, smax, mw, hold, k;
    smin = 32'(cfg.short_min_ms);
    smax = 32'(cfg.short_max_ms);
    mw = 32'(cfg.multi_window_ms);
    for (k = 0; k < n; k++) begin
      hold = $urandom_range(smin, smax);
      push_poll(cursor_ms, 1'b1);
      cursor_ms = cursor_ms + hold;
      push_poll(cursor_ms, 1'b0);
      cursor_ms = cursor_ms + $urandom_range(0, mw - smax - 1);
    end
    cursor_ms = cursor_ms + mw;
    push_poll(cursor_ms, 1'b0);        // expiry reports the saturated count
  endtask

  task automatic check_field(string fname, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      errs++;
      if (errs <= 10) begin
        $display("mismatch in result %0d, %s: expected %0h, got %0h", n_results, fname, want,
                 got);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence of phases
  // ---------------------------------------------------------------------------

  initial begin
    gs = '0;
    cfg.short_min_ms = bgd_pkg::SHORT_MIN_RST;
    cfg.short_max_ms = bgd_pkg::SHORT_MAX_RST;
    cfg.multi_window_ms = bgd_pkg::MULTI_WIN_RST;
    cfg.long_hold_ms = bgd_pkg::LONG_PRESS_RST;
    cfg.repeat_ms = bgd_pkg::REPEAT_RST;
    cfg.report_interval_ms = bgd_pkg::REPORT_INTV_RST;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: directed polls, then random gestures with a long receiver hold-off
    queue_directed();
    queue_gestures(330);
    hold_reqs++;
    settle();

    // low extremes: zero intervals fire on the press poll itself
    load_regs(16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0);
    queue_gestures(200);
    settle();

    // high extremes, run without any idling
    calm = 1'b1;
    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_gestures(200);
    settle();
    calm = 1'b0;

    // tight timing: many events per hold, count saturation, second hold-off
    load_regs(16'd5, 16'd40, 16'd300, 16'd100, 16'd15, 16'd10);
    queue_click_train(262);
    queue_gestures(240);
    hold_reqs++;
    settle();

    // writes past the last register change nothing, then moderate random settings
    write_reg(REG_SPARE_LO, 16'($urandom()));
    write_reg(REG_SPARE_HI, 16'($urandom()));
    load_regs(16'($urandom_range(0, 200)), 16'($urandom_range(0, 2000)),
              16'($urandom_range(1, 2000)), 16'($urandom_range(0, 3000)),
              16'($urandom_range(1, 500)), 16'($urandom_range(0, 500)));
    queue_gestures(150);
    settle();

    // any legal setting
    load_regs(16'($urandom()), 16'($urandom()), 16'($urandom_range(1, 65535)),
              16'($urandom()), 16'($urandom_range(1, 65535)), 16'($urandom()));
    queue_gestures(150);
    settle();

    $display("covered %0d polls, %0d results: %0d clicks (peak count %0d), %0d window expiries",
             n_polls, n_results, n_clicks, peak_count, n_expiries);
    $display("%0d long presses, %0d repeats, %0d held reports, %0d stalled input cycles",
             n_long, n_repeats, n_reports, n_in_stalls);
    if (errs == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errs);
      $display("status: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: offers polls from the backlog, holds a stalled transfer unchanged
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (poll_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
        in_valid <= 1'b1;
        in_now_ms <= poll_backlog[0].now_ms;
        in_pressed <= poll_backlog[0].pressed;
        poll_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus long hold-offs counted here
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_reqs) begin
      out_stall <= 1'b1;
      hold_done <= hold_done + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 10);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each input transfer, compare on each result transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && in_stall) begin
        n_in_stalls++;
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (predicted_events.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("result %0d arrived with nothing expected", n_results);
          end
        end else begin
          oldest = predicted_events.pop_front();
          check_field("press_edge", 32'(out_press_edge), 32'(oldest.press_edge));
          check_field("release_edge", 32'(out_release_edge), 32'(oldest.release_edge));
          check_field("click", 32'(out_click), 32'(oldest.click));
          check_field("click_num", 32'(out_click_num), 32'(oldest.click_num));
          check_field("click_timeout", 32'(out_click_timeout), 32'(oldest.click_timeout));
          check_field("final_count", 32'(out_final_count), 32'(oldest.final_count));
          check_field("duration_report", 32'(out_duration_report),
                      32'(oldest.duration_report));
          check_field("held_ms", out_held_ms, oldest.held_ms);
          check_field("long_press", 32'(out_long_press), 32'(oldest.long_press));
          check_field("long_repeat", 32'(out_long_repeat), 32'(oldest.long_repeat));
          check_field("is_down", 32'(out_is_down), 32'(oldest.is_down));
        end
      end
      if (in_valid && !in_stall) begin
        classify_poll(in_now_ms, in_pressed, fresh);
        predicted_events.push_back(fresh);
        n_polls++;
        n_clicks += 32'(fresh.click);
        n_expiries += 32'(fresh.click_timeout);
        n_long += 32'(fresh.long_press);
        n_repeats += 32'(fresh.long_repeat);
        n_reports += 32'(fresh.duration_report);
        if (32'(fresh.click_num) > peak_count) begin
          peak_count = 32'(fresh.click_num);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles,
               predicted_events.size());
      $display("status: fail");
      $finish;
    end
  end

endmodule

/* filelist.f */
hw/rtl/bgd_pkg.sv
hw/rtl/bgd_eval.sv
hw/rtl/button_gesture_detector.sv
tb/sv/button_gesture_detector_tb.sv
